### hdl/rbrw_pkg.sv
// shared types and constants for the register bank read/write core
`default_nettype none
package rbrw_pkg;

  localparam int DATA_W     = 16;
  localparam int CNT_W      = 7;
  localparam int SUM_W      = 17;
  localparam int RESET_ONES = 3;
  localparam logic [DATA_W-1:0] BASE_RESET = 16'd1;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_READ   = 4'b1000
  } state_t;

  typedef struct packed {
    logic we;
    logic re;
  } bank_ctl_t;

endpackage
`default_nettype wire

### hdl/rbrw_alu.sv
// shared 17-bit add/subtract unit used by the sequencer
`default_nettype none
module rbrw_alu (
  input  wire rbrw_pkg::alu_op_t          op,
  input  wire [rbrw_pkg::SUM_W-1:0]       a,
  input  wire [rbrw_pkg::SUM_W-1:0]       b,
  output logic [rbrw_pkg::SUM_W-1:0]      sum
);
  import rbrw_pkg::*;

  always_comb begin
    unique case (op)
      ALU_SUB: sum = a - b;
      default: sum = a + b;
    endcase
  end

endmodule
`default_nettype wire

### hdl/rbrw_bank.sv
// register storage with per-entry valid bits and registered read
`default_nettype none
module rbrw_bank #(
  parameter int TABLE_DEPTH = 64,
  parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire rbrw_pkg::bank_ctl_t         ctl,
  input  wire [AW-1:0]                     waddr,
  input  wire [rbrw_pkg::DATA_W-1:0]       wdata,
  input  wire [AW-1:0]                     raddr,
  output logic [rbrw_pkg::DATA_W-1:0]      rdata
);
  import rbrw_pkg::*;

  logic [DATA_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  logic [DATA_W-1:0]      rd_mem;
  logic                   rd_valid;
  logic                   rd_one;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rd_mem   <= mem[raddr];
      rd_valid <= valid[raddr];
      rd_one   <= {{(DATA_W-AW){1'b0}}, raddr} < DATA_W'(RESET_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // unwritten entries read as their reset value
  assign rdata = rd_valid ? rd_mem : {{(DATA_W-1){1'b0}}, rd_one};

endmodule
`default_nettype wire

### hdl/register_bank_read_write_core.sv
// top level: request sequencer around the shared adder and the register bank
//
//   channel   signals                                             transfer when
//   request   start busy req_type start_address reg_count         start & !busy
//             write_value
//   result    done read_value status last written_flag            done
//   config    cfg_we cfg_data                                     cfg_we
//
// a request runs its range check on the one shared adder, start - base in
// the check state, then idx + count in the decide state, then reads one
// register per cycle; the results are registered and a run of reads streams
// one result a cycle
// errors, writes and zero-count reads give a single result
// reset clears the sequencer, the written flag, the valid bits and sets the
// base to 1; the receiver cannot stall, results are never held back
`default_nettype none
module register_bank_read_write_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_we,
  input  wire [rbrw_pkg::DATA_W-1:0]        cfg_data,
  input  wire                               start,
  output logic                              busy,
  input  wire                               req_type,
  input  wire [rbrw_pkg::DATA_W-1:0]        start_address,
  input  wire [rbrw_pkg::CNT_W-1:0]         reg_count,
  input  wire [rbrw_pkg::DATA_W-1:0]        write_value,
  output logic                              done,
  output logic [rbrw_pkg::DATA_W-1:0]       read_value,
  output logic                              status,
  output logic                              last,
  output logic                              written_flag
);
  import rbrw_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // wide enough to hold the bank depth itself as the end index
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  // base address register
  logic [DATA_W-1:0] base_address;

  // latched request
  logic              req_q;
  logic [DATA_W-1:0] start_q;
  logic [CNT_W-1:0]  count_q;
  logic [DATA_W-1:0] wval_q;

  // range check and read walk
  logic [SUM_W-1:0] diff;       // start - base, msb set when start < base
  logic [CW-1:0]    addr;
  logic [CW-1:0]    end_idx;
  logic             write_seen;
  logic             use_mem;

  // shared adder
  alu_op_t          alu_op;
  logic [SUM_W-1:0] alu_a, alu_b, alu_sum;

  logic      range_err, idx_err, single;
  bank_ctl_t bank_ctl;
  logic [DATA_W-1:0] bank_rdata;

  rbrw_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  rbrw_bank #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_bank (
    .clk   (clk),
    .rst   (rst),
    .ctl   (bank_ctl),
    .waddr (diff[AW-1:0]),
    .wdata (wval_q),
    .raddr (addr[AW-1:0]),
    .rdata (bank_rdata)
  );

  // adder operand select per sequencer step
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = {{(SUM_W-CW){1'b0}}, addr};
    alu_b  = SUM_W'(1);
    unique case (state)
      ST_CHECK: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, start_q};
        alu_b  = {1'b0, base_address};
      end
      ST_DECIDE: begin
        alu_a = {1'b0, diff[DATA_W-1:0]};
        alu_b = {{(SUM_W-CNT_W){1'b0}}, count_q};
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // range checks, valid in decide
  assign range_err = diff[SUM_W-1] || (alu_sum > SUM_W'(TABLE_DEPTH));
  // write at one past the end passes the run check but names no register
  assign idx_err   = diff[DATA_W-1:0] >= DATA_W'(TABLE_DEPTH);
  assign single    = range_err || (req_q == REQ_WRITE) || (count_q == '0);

  always_comb begin
    bank_ctl.we = (state == ST_DECIDE) && !range_err && (req_q == REQ_WRITE) && !idx_err;
    bank_ctl.re = (state == ST_READ);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_CHECK;
      ST_CHECK:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = single ? ST_IDLE : ST_READ;
      ST_READ:   if (alu_sum[CW-1:0] == end_idx) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_address <= BASE_RESET;
      write_seen   <= 1'b0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        base_address <= cfg_data;
      end
      if (bank_ctl.we) begin
        write_seen <= 1'b1;
      end
      done <= ((state == ST_DECIDE) && single) || (state == ST_READ);
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q   <= req_type;
      start_q <= start_address;
      count_q <= reg_count;
      wval_q  <= write_value;
    end
    if (state == ST_CHECK) begin
      diff <= alu_sum;
    end
    unique case (state)
      ST_DECIDE: begin
        // first index of the run and one past its end
        addr    <= diff[CW-1:0];
        end_idx <= alu_sum[CW-1:0];
        use_mem <= 1'b0;
        status  <= (range_err || ((req_q == REQ_WRITE) && idx_err)) ? STATUS_ERR : STATUS_OK;
        last    <= 1'b1;
      end
      ST_READ: begin
        addr    <= alu_sum[CW-1:0];
        use_mem <= 1'b1;
        status  <= STATUS_OK;
        last    <= (alu_sum[CW-1:0] == end_idx);
      end
      default: begin
        use_mem <= use_mem;
      end
    endcase
  end

  assign read_value   = use_mem ? bank_rdata : '0;
  assign written_flag = write_seen;

endmodule
`default_nettype wire

### tb/sv/register_bank_read_write_core_test.sv
// testbench for the register bank read/write core: directed and random requests checked per result
`timescale 1ns / 100ps
module register_bank_read_write_core_test;
  import rbrw_pkg::*;

  localparam int DEPTH          = 64;
  localparam int ITEMS_PER_PHASE = 55;
  // limit sized well above the slowest run of about 470 requests
  localparam int CYCLE_LIMIT    = 300000;

  // one result word as the block should produce it
  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              status;
    logic              last;
    logic              written;
  } reply_t;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_we        = 1'b0;
  logic [DATA_W-1:0] cfg_data      = '0;
  logic              start         = 1'b0;
  logic              req_type      = REQ_READ;
  logic [DATA_W-1:0] start_address = '0;
  logic [CNT_W-1:0]  reg_count     = '0;
  logic [DATA_W-1:0] write_value   = '0;
  wire               busy;
  wire               done;
  wire  [DATA_W-1:0] read_value;
  wire               status;
  wire               last;
  wire               written_flag;

  // shadow copy of the bank contents, sticky flag and base register
  logic [DATA_W-1:0] shadow_regs [DEPTH];
  logic              shadow_written;
  logic [DATA_W-1:0] shadow_base;

  // results predicted but not yet seen on the result port, oldest first
  reply_t awaited_replies [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit idle_gaps      = 1'b1;

  register_bank_read_write_core #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .start_address(start_address),
    .reg_count    (reg_count),
    .write_value  (write_value),
    .done         (done),
    .read_value   (read_value),
    .status       (status),
    .last         (last),
    .written_flag (written_flag)
  );

  always #10 clk = ~clk;

  // hard stop in case the block hangs or stops answering
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("** register_bank_read_write_core: FAILED **");
      $finish;
    end
  end

  function automatic void queue_reply(input logic [DATA_W-1:0] word, input logic st,
                                      input logic lst);
    reply_t r;
    r.word    = word;
    r.status  = st;
    r.last    = lst;
    r.written = shadow_written;
    awaited_replies.push_back(r);
  endfunction

  // works out the answer to one accepted request and updates the shadow state
  function automatic void predict_bank_reply(input logic req, input logic [DATA_W-1:0] addr,
                                             input logic [CNT_W-1:0] cnt,
                                             input logic [DATA_W-1:0] wval);
    int unsigned first;
    int unsigned span;
    int unsigned lo;
    int unsigned idx;
    first = 32'(addr);
    span  = 32'(cnt);
    lo    = 32'(shadow_base);
    // range check in wide arithmetic, no 16-bit wrap; a write one past the
    // bank with zero count passes the run check but names no register
    if (first < lo || first + span > lo + DEPTH ||
        (req == REQ_WRITE && first - lo >= DEPTH)) begin
      queue_reply('0, STATUS_ERR, 1'b1);
      return;
    end
    idx = first - lo;
    if (req == REQ_WRITE) begin
      shadow_regs[idx] = wval;
      shadow_written   = 1'b1;
      queue_reply('0, STATUS_OK, 1'b1);
    end else if (span == 0) begin
      queue_reply('0, STATUS_OK, 1'b1);
    end else begin
      for (int k = 0; k < span; k++)
        queue_reply(shadow_regs[idx + k], STATUS_OK, k == span - 1);
    end
  endfunction

  function automatic void compare_field(input string name, input logic [DATA_W-1:0] want_v,
                                        input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // result checker: every done strobe is one transfer, matched to the oldest
  // awaited result field by field
  always @(posedge clk) begin : check_results
    reply_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual value %h status %b last %b",
                 $time, read_value, status, last);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        compare_field("read_value", want.word, read_value);
        compare_field("status", {15'd0, want.status}, {15'd0, status});
        compare_field("last", {15'd0, want.last}, {15'd0, last});
        compare_field("written_flag", {15'd0, want.written}, {15'd0, written_flag});
      end
    end
  end

  // one request transfer; entered and left at a rising edge
  // start stays high across back-to-back requests, dropped only for a gap
  task automatic send_request(input logic req, input logic [DATA_W-1:0] addr, input int cnt,
                              input logic [DATA_W-1:0] wval);
    int gap;
    start         <= 1'b1;
    req_type      <= req;
    start_address <= addr;
    reg_count     <= cnt[CNT_W-1:0];
    write_value   <= wval;
    @(posedge clk);
    // busy as sampled here is its value just before this edge
    while (busy !== 1'b0) @(posedge clk);
    predict_bank_reply(req, addr, cnt[CNT_W-1:0], wval);
    gap = idle_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // block idle: no start, every awaited result in, a spare wait, then busy low
  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic program_base(input logic [DATA_W-1:0] value);
    wait_idle();
    cfg_we      <= 1'b1;
    cfg_data    <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_base  = value;
  endtask

  // reset image, zero-count reads, runs at both ends of the bank, range errors
  task automatic test_reset_image();
    send_request(REQ_READ, 16'd1, 64, 16'h0000);     // whole bank after reset
    send_request(REQ_READ, 16'd1, 0, 16'h0000);      // zero-count read at base
    send_request(REQ_READ, 16'd0, 1, 16'h0000);      // below base
    send_request(REQ_READ, 16'd65, 0, 16'h0000);     // zero count one past the bank
    send_request(REQ_READ, 16'd64, 1, 16'h0000);     // top register
    send_request(REQ_READ, 16'd64, 2, 16'h0000);     // run past the top
    send_request(REQ_WRITE, 16'd65, 0, 16'h1234);    // write one past the bank
  endtask

  // writes at both ends, widest count, sticky flag, read-back
  task automatic test_single_writes();
    send_request(REQ_WRITE, 16'd1, 0, 16'hFFFF);     // first write sets the flag
    send_request(REQ_WRITE, 16'd64, 1, 16'h8001);
    send_request(REQ_WRITE, 16'd2, 127, 16'h7777);   // count too wide
    send_request(REQ_READ, 16'hFFFF, 127, 16'h0000); // both fields at max
    send_request(REQ_READ, 16'd1, 3, 16'h0000);
    send_request(REQ_READ, 16'd62, 3, 16'h0000);
    send_request(REQ_WRITE, 16'd33, 1, 16'h0000);
    send_request(REQ_WRITE, 16'hFFFF, 0, 16'hFFFF);
  endtask

  // base register at zero, at the top of the address space and just below it
  task automatic test_base_extremes();
    program_base(16'h0000);
    send_request(REQ_READ, 16'h0000, 64, 16'h0000);
    send_request(REQ_WRITE, 16'h0000, 0, 16'h5A5A);
    send_request(REQ_READ, 16'h0040, 0, 16'h0000);
    send_request(REQ_WRITE, 16'h0040, 0, 16'h0101);
    program_base(16'hFFFF);
    send_request(REQ_READ, 16'hFFFF, 64, 16'h0000);  // end lies past 16 bits
    send_request(REQ_READ, 16'hFFFF, 65, 16'h0000);
    send_request(REQ_WRITE, 16'hFFFF, 1, 16'hA5A5);
    send_request(REQ_READ, 16'hFFFE, 1, 16'h0000);
    program_base(16'hFFC0);
    send_request(REQ_READ, 16'hFFC0, 64, 16'h0000);
    send_request(REQ_READ, 16'hFFFF, 1, 16'h0000);
  endtask

  // mostly in-range requests with random content, the rest edge and noise
  task automatic random_request();
    logic        req;
    int unsigned idx;
    int unsigned roomy;
    int unsigned cnt;
    int unsigned addr;
    req = ($urandom_range(0, 99) < 40) ? REQ_WRITE : REQ_READ;
    if ($urandom_range(0, 99) < 80) begin
      idx   = $urandom_range(0, DEPTH - 1);
      roomy = DEPTH - idx;
      // short runs mostly, now and then a long one
      if (req == REQ_READ && $urandom_range(0, 9) != 0)
        cnt = $urandom_range(0, (roomy < 8) ? roomy : 8);
      else
        cnt = $urandom_range(0, roomy);
      addr = shadow_base + idx;
    end else if ($urandom_range(0, 1) == 0) begin
      // around both ends of the bank
      addr = shadow_base + $urandom_range(0, DEPTH + 3) - 2;
      cnt  = $urandom_range(0, 70);
    end else begin
      addr = $urandom_range(0, 16'hFFFF);
      cnt  = $urandom_range(0, 127);
    end
    send_request(req, addr[DATA_W-1:0], cnt, DATA_W'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic test_random_traffic();
    logic [DATA_W-1:0] bases [8];
    bases[0] = DATA_W'($urandom_range(0, 16'hFFFF));
    bases[1] = 16'h0000;
    bases[2] = DATA_W'($urandom_range(0, 16'hFFFF));
    bases[3] = 16'hFFFF;
    bases[4] = DATA_W'($urandom_range(0, 16'hFFFF));
    bases[5] = 16'hFFC0;
    bases[6] = DATA_W'($urandom_range(0, 16'hFFFF));
    bases[7] = BASE_RESET;
    for (int p = 0; p < 8; p++) begin
      program_base(bases[p]);
      // some phases run back to back with no idle gaps
      idle_gaps = (p % 3 != 2);
      repeat (ITEMS_PER_PHASE) random_request();
    end
    idle_gaps = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++)
      shadow_regs[i] = (i < RESET_ONES) ? 16'd1 : 16'd0;
    shadow_written = 1'b0;
    shadow_base    = BASE_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_image();
    test_single_writes();
    test_base_extremes();
    test_random_traffic();

    // drain, then wait on for stray results
    wait_idle();
    repeat (8) @(posedge clk);

    if (mismatch_count == 0)
      $display("** register_bank_read_write_core: PASSED **");
    else
      $display("** register_bank_read_write_core: FAILED **");
    $finish;
  end

endmodule
